FILE: sv/oginf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oginf_pkg
// Shared types and constants of the occupancy grid inflation block: payload
// structs, configuration view and the controller/datapath command interface.
// ----------------------------------------------------------------------------
package oginf_pkg;

    // Cell codes
    localparam logic [7:0] FREE_CELL     = 8'd255;
    localparam logic [7:0] OBSTACLE_CELL = 8'd0;
    localparam logic [7:0] INFLATED_CELL = 8'd5;

    // Item operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Signed width of a neighbor coordinate (0..255 plus or minus radius)
    localparam int COORD_W = 10;

    typedef struct packed {
        logic       op;
        logic [7:0] x_pos;
        logic [7:0] y_pos;
        logic [7:0] pixel_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] cell_value;
        logic       coord_error;
    } t_out_item;

    // Effective (clamped) configuration seen by the datapath
    typedef struct packed {
        logic [8:0] width;
        logic [8:0] height;
        logic [3:0] radius;
    } t_eff_cfg;

    // Result kind latched by the controller
    typedef enum logic [1:0] {
        RES_ERR,
        RES_STORED,
        RES_INFL
    } t_res_sel;

    typedef struct packed {
        logic     capture;
        logic     mem_write;
        logic     rd_center;
        logic     hold_center;
        logic     scan_init;
        logic     scan_step;
        logic     load_out;
        t_res_sel res_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic in_range;
        logic is_write;
        logic center_free;
        logic hit;
        logic scan_last;
        logic out_free;
    } t_dp_sts;

    // Square of a small signed offset, |v| <= 15
    function automatic logic [9:0] sq_offset(input logic signed [4:0] v);
        logic [4:0] mag;
        logic [9:0] ext;
        mag = v[4] ? 5'(-v) : 5'(v);
        ext = {6'd0, mag[3:0]};
        return 10'(ext * ext);
    endfunction

endpackage

FILE: sv/oginf_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oginf_regs
// APB-style configuration registers: map width, map height and inflation
// radius, with the clamped values handed to the datapath.
// ----------------------------------------------------------------------------
module oginf_regs
    import oginf_pkg::*;
#(
    parameter int MAP_W      = 256,
    parameter int MAP_H      = 256,
    parameter int MAX_RADIUS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_eff_cfg    o_eff_cfg
);

    typedef enum logic [1:0] {
        REG_MAP_WIDTH,
        REG_MAP_HEIGHT,
        REG_INFLATE_RADIUS,
        REG_UNUSED
    } t_reg_idx;

    localparam logic [8:0] W_MAX = (MAP_W > 511) ? 9'd511 : 9'(MAP_W);
    localparam logic [8:0] H_MAX = (MAP_H > 511) ? 9'd511 : 9'(MAP_H);
    localparam logic [3:0] R_MAX = (MAX_RADIUS > 15) ? 4'd15 : 4'(MAX_RADIUS);

    logic [8:0] r_map_width;
    logic [8:0] r_map_height;
    logic [3:0] r_inflate_radius;
    logic       wr_en;
    t_reg_idx   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[3:2]);

    // Write registers on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width      <= 9'd256;
            r_map_height     <= 9'd256;
            r_inflate_radius <= 4'd4;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MAP_WIDTH:      r_map_width      <= pwdata[8:0];
                REG_MAP_HEIGHT:     r_map_height     <= pwdata[8:0];
                REG_INFLATE_RADIUS: r_inflate_radius <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Return the raw register value
    always_comb begin
        case (reg_idx)
            REG_MAP_WIDTH:      prdata = {23'd0, r_map_width};
            REG_MAP_HEIGHT:     prdata = {23'd0, r_map_height};
            REG_INFLATE_RADIUS: prdata = {28'd0, r_inflate_radius};
            default:            prdata = 32'd0;
        endcase
    end

    // Clamp sizes to 1..max and radius to max
    always_comb begin
        if (r_map_width == 9'd0)      o_eff_cfg.width = 9'd1;
        else if (r_map_width > W_MAX) o_eff_cfg.width = W_MAX;
        else                          o_eff_cfg.width = r_map_width;

        if (r_map_height == 9'd0)      o_eff_cfg.height = 9'd1;
        else if (r_map_height > H_MAX) o_eff_cfg.height = H_MAX;
        else                           o_eff_cfg.height = r_map_height;

        o_eff_cfg.radius = (r_inflate_radius > R_MAX) ? R_MAX : r_inflate_radius;
    end

endmodule

FILE: sv/oginf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oginf_ctrl
// Controller: sequences capture, range check, grid write, center read,
// neighborhood scan and result hand-off.
// ----------------------------------------------------------------------------
module oginf_ctrl
    import oginf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_CENTER,
        S_SCAN,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state   r_state,   n_state;
    t_res_sel r_res_sel, n_res_sel;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and datapath commands
    always_comb begin
        n_state       = r_state;
        n_res_sel     = r_res_sel;
        o_cmd         = '0;
        o_cmd.res_sel = r_res_sel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.in_range) begin
                    n_res_sel = RES_ERR;
                    n_state   = S_OUT;
                end else if (i_sts.is_write) begin
                    o_cmd.mem_write = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.rd_center = 1'b1;
                    n_state         = S_CENTER;
                end
            end
            S_CENTER: begin
                o_cmd.hold_center = 1'b1;
                if (!i_sts.center_free) begin
                    n_res_sel = RES_STORED;
                    n_state   = S_OUT;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                // Stop as soon as an obstacle comes back from memory
                if (i_sts.hit) begin
                    n_res_sel = RES_INFL;
                    n_state   = S_OUT;
                end else begin
                    o_cmd.scan_step = 1'b1;
                    if (i_sts.scan_last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_res_sel = i_sts.hit ? RES_INFL : RES_STORED;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and latched result kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_res_sel <= RES_ERR;
        end else begin
            r_state   <= n_state;
            r_res_sel <= n_res_sel;
        end
    end

endmodule

FILE: sv/oginf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oginf_dp
// Datapath: grid memory, item registers, neighborhood offset counters with
// bounds and disk test, and the output register.
// ----------------------------------------------------------------------------
module oginf_dp
    import oginf_pkg::*;
#(
    parameter int MAP_W = 256,
    parameter int MAP_H = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_eff_cfg  i_eff_cfg,
    input  t_in_item  i_in_data,
    input  logic      i_out_ready,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts
);

    localparam int XW    = ($clog2(MAP_W) > 8) ? 8 : $clog2(MAP_W);
    localparam int YW    = ($clog2(MAP_H) > 8) ? 8 : $clog2(MAP_H);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;

    logic [7:0]  r_mem [DEPTH];
    logic [7:0]  r_rdata;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] ctr_addr;
    logic [AW-1:0] nb_addr;

    logic       r_op;
    logic [7:0] r_x;
    logic [7:0] r_y;
    logic [7:0] r_pix;
    logic [7:0] r_center;

    logic signed [4:0] r_dx;
    logic signed [4:0] r_dy;
    logic signed [4:0] rad_s;
    logic              r_chk;

    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic        in_bounds;
    logic        in_disk;
    logic [10:0] dist2;
    logic [9:0]  rad2;

    logic      r_out_valid;
    t_out_item r_out_data;
    logic      out_free;

    // Capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_in_data.op;
            r_x   <= i_in_data.x_pos;
            r_y   <= i_in_data.y_pos;
            r_pix <= i_in_data.pixel_value;
        end
        if (i_cmd.hold_center) begin
            r_center <= r_rdata;
        end
    end

    // Neighbor coordinates and their checks
    assign rad_s     = $signed({1'b0, i_eff_cfg.radius});
    assign nx        = $signed({2'b00, r_x}) + COORD_W'(r_dx);
    assign ny        = $signed({2'b00, r_y}) + COORD_W'(r_dy);
    assign in_bounds = !nx[COORD_W-1] && (nx[8:0] < i_eff_cfg.width) &&
                       !ny[COORD_W-1] && (ny[8:0] < i_eff_cfg.height);
    assign dist2     = {1'b0, sq_offset(r_dx)} + {1'b0, sq_offset(r_dy)};
    assign rad2      = sq_offset(rad_s);
    assign in_disk   = dist2 <= {1'b0, rad2};

    assign ctr_addr = {r_y[YW-1:0], r_x[XW-1:0]};
    assign nb_addr  = {ny[YW-1:0], nx[XW-1:0]};
    assign rd_addr  = i_cmd.rd_center ? ctr_addr : nb_addr;

    // Grid memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write) begin
            r_mem[ctr_addr] <= r_pix;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // Walk the square row by row
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_dx <= -rad_s;
            r_dy <= -rad_s;
        end else if (i_cmd.scan_step) begin
            if (r_dx == rad_s) begin
                r_dx <= -rad_s;
                r_dy <= r_dy + 5'sd1;
            end else begin
                r_dx <= r_dx + 5'sd1;
            end
        end
    end

    // Mark reads whose returned cell counts toward inflation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk <= 1'b0;
        end else begin
            r_chk <= i_cmd.scan_step && in_bounds && in_disk;
        end
    end

    // Output register
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            case (i_cmd.res_sel)
                RES_ERR: begin
                    r_out_data.cell_value  <= 8'd0;
                    r_out_data.coord_error <= 1'b1;
                end
                RES_STORED: begin
                    r_out_data.cell_value  <= r_center;
                    r_out_data.coord_error <= 1'b0;
                end
                RES_INFL: begin
                    r_out_data.cell_value  <= INFLATED_CELL;
                    r_out_data.coord_error <= 1'b0;
                end
                default: begin
                    r_out_data.cell_value  <= 8'd0;
                    r_out_data.coord_error <= 1'b1;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Status back to the controller
    assign o_sts.in_range    = ({1'b0, r_x} < i_eff_cfg.width) &&
                               ({1'b0, r_y} < i_eff_cfg.height);
    assign o_sts.is_write    = (r_op == OP_WRITE);
    assign o_sts.center_free = (r_rdata == FREE_CELL);
    assign o_sts.hit         = r_chk && (r_rdata == OBSTACLE_CELL);
    assign o_sts.scan_last   = (r_dx == rad_s) && (r_dy == rad_s);
    assign o_sts.out_free    = out_free;

endmodule

FILE: sv/occupancy_grid_obstacle_inflation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// occupancy_grid_obstacle_inflation
// Gray occupancy grid with disk-shaped obstacle inflation on read.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A write inside the map gives no result; an
// item outside the configured size gives an error result, and a read of a cell
// that is not free (255) returns the stored value. A read of a free cell scans
// the (2R+1) x (2R+1) square around it through the single read port of the
// grid memory, one neighbor per cycle, and stops at the first obstacle inside
// radius R. A waiting result is held in an output register; a further result
// waits only until that register is taken. Grid contents are not cleared by
// reset; read only cells that were written.
// ----------------------------------------------------------------------------
module occupancy_grid_obstacle_inflation
    import oginf_pkg::*;
#(
    parameter int MAP_W      = 256,
    parameter int MAP_H      = 256,
    parameter int MAX_RADIUS = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_eff_cfg eff_cfg;
    t_dp_cmd  dp_cmd;
    t_dp_sts  dp_sts;

    oginf_regs #(
        .MAP_W      (MAP_W),
        .MAP_H      (MAP_H),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_eff_cfg (eff_cfg)
    );

    oginf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    oginf_dp #(
        .MAP_W (MAP_W),
        .MAP_H (MAP_H)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_eff_cfg   (eff_cfg),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts)
    );

endmodule

FILE: sv/oginf_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oginf_chk
// Port-level checks of the occupancy grid inflation block, bound to the top.
// ----------------------------------------------------------------------------
module oginf_chk
    import oginf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // Hold a stalled input transaction
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input changed or dropped while waiting");

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed or dropped while stalled");

    // Drop ready right after an input transaction: one item at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while previous item in flight");

    // An error result carries a zero cell value
    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.coord_error |-> o_out_data.cell_value == 8'd0)
        else $error("error result with nonzero cell value");

    // No result leaves reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind occupancy_grid_obstacle_inflation oginf_chk u_oginf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

FILE: tb/tb_occupancy_grid_obstacle_inflation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_occupancy_grid_obstacle_inflation
// Self-checking bench for the occupancy grid inflation block. A shadow copy of
// the grid and of the map registers predicts every read and every coordinate
// error; results are matched in order against the output stream. Stimulus runs
// a set of directed corner cases, then map phases that load a work area and
// mix reads, rewrites and out-of-range items under random idling, one long
// output stall, and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_occupancy_grid_obstacle_inflation;
    import oginf_pkg::*;

    localparam int GRID_W           = 256;
    localparam int GRID_H           = 256;
    localparam int GRID_CELLS       = GRID_W * GRID_H;
    localparam int MAX_RADIUS       = 15;
    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 12;
    localparam int SETTLE_CYCLES    = 16;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int MAX_REPORTS      = 40;
    localparam int AREA_SPAN_MAX    = 14;
    localparam longint TIMEOUT_NS   = 150_000_000;

    localparam logic [3:0] ADDR_MAP_WIDTH      = 4'h0;
    localparam logic [3:0] ADDR_MAP_HEIGHT     = 4'h4;
    localparam logic [3:0] ADDR_INFLATE_RADIUS = 4'h8;

    typedef enum int {
        AREA_LOW_CORNER,
        AREA_HIGH_CORNER,
        AREA_ANYWHERE
    } t_area_place;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the grid and of the map registers
    logic [7:0]  grid_mirror [GRID_CELLS];
    bit          written_cells [GRID_CELLS];
    logic [8:0]  map_width_reg  = 9'd256;
    logic [8:0]  map_height_reg = 9'd256;
    logic [3:0]  radius_reg     = 4'd4;

    t_out_item   awaited_outputs [$];
    int          mismatch_count = 0;
    int          result_index   = 0;
    bit          tx_idle_en;
    bit          rx_idle_en;
    int          hold_requests  = 0;
    int          hold_served    = 0;

    // Work area of the current map phase
    int          area_x0;
    int          area_y0;
    int          area_w;
    int          area_h;

    occupancy_grid_obstacle_inflation dut (.*);

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function automatic int clamp_dim(input logic [8:0] v, input int limit);
        if (v == 9'd0) return 1;
        if (int'(v) > limit) return limit;
        return int'(v);
    endfunction

    function automatic int active_radius();
        return (int'(radius_reg) > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
    endfunction

    // Stored value, or the inflated code when an obstacle lies in the disk
    function automatic logic [7:0] inflated_lookup(input int x, input int y);
        int         w;
        int         h;
        int         r;
        int         nx;
        int         ny;
        logic [7:0] center;
        w = clamp_dim(map_width_reg, GRID_W);
        h = clamp_dim(map_height_reg, GRID_H);
        r = active_radius();
        center = grid_mirror[y * GRID_W + x];
        if (center != FREE_CELL) return center;
        for (ny = y - r; ny <= y + r; ny++) begin
            for (nx = x - r; nx <= x + r; nx++) begin
                if (ny >= 0 && ny < h && nx >= 0 && nx < w &&
                    (nx - x) * (nx - x) + (ny - y) * (ny - y) <= r * r &&
                    grid_mirror[ny * GRID_W + nx] == OBSTACLE_CELL) begin
                    return INFLATED_CELL;
                end
            end
        end
        return center;
    endfunction

    // Apply one accepted transaction to the shadow grid and queue its result
    function automatic void predict_grid_access(input t_in_item item);
        int        w;
        int        h;
        int        idx;
        t_out_item res;
        w = clamp_dim(map_width_reg, GRID_W);
        h = clamp_dim(map_height_reg, GRID_H);
        idx = int'(item.y_pos) * GRID_W + int'(item.x_pos);
        if (int'(item.x_pos) >= w || int'(item.y_pos) >= h) begin
            res.cell_value  = 8'd0;
            res.coord_error = 1'b1;
            awaited_outputs = {awaited_outputs, res};
        end else if (item.op == OP_WRITE) begin
            grid_mirror[idx]   = item.pixel_value;
            written_cells[idx] = 1'b1;
        end else begin
            res.cell_value  = inflated_lookup(item.x_pos, item.y_pos);
            res.coord_error = 1'b0;
            awaited_outputs = {awaited_outputs, res};
        end
    endfunction

    // A read is legal only when its whole scan square inside the map is loaded
    function automatic bit cell_readable(input int x, input int y);
        int w;
        int h;
        int r;
        int nx;
        int ny;
        w = clamp_dim(map_width_reg, GRID_W);
        h = clamp_dim(map_height_reg, GRID_H);
        r = active_radius();
        for (ny = y - r; ny <= y + r; ny++)
            for (nx = x - r; nx <= x + r; nx++)
                if (ny >= 0 && ny < h && nx >= 0 && nx < w &&
                    !written_cells[ny * GRID_W + nx]) begin
                    return 1'b0;
                end
        return 1'b1;
    endfunction

    function automatic bit pick_readable(output int x, output int y);
        int tries;
        for (tries = 0; tries < 40; tries++) begin
            x = area_x0 + $urandom_range(0, area_w - 1);
            y = area_y0 + $urandom_range(0, area_h - 1);
            if (cell_readable(x, y)) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_in_item grid_item(input logic op, input int x, input int y,
                                           input logic [7:0] pix);
        t_in_item item;
        item.op          = op;
        item.x_pos       = 8'(x);
        item.y_pos       = 8'(y);
        item.pixel_value = pix;
        return item;
    endfunction

    // Mostly free cells, a fair share of obstacles, some gray noise
    function automatic logic [7:0] random_pixel();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return FREE_CELL;
        if (roll < 85) return OBSTACLE_CELL;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void place_work_area(input t_area_place place);
        int w;
        int h;
        w = clamp_dim(map_width_reg, GRID_W);
        h = clamp_dim(map_height_reg, GRID_H);
        area_w = (w <= AREA_SPAN_MAX) ? w : $urandom_range(6, AREA_SPAN_MAX);
        area_h = (h <= AREA_SPAN_MAX) ? h : $urandom_range(6, AREA_SPAN_MAX);
        case (place)
            AREA_LOW_CORNER: begin
                area_x0 = 0;
                area_y0 = 0;
            end
            AREA_HIGH_CORNER: begin
                area_x0 = w - area_w;
                area_y0 = h - area_h;
            end
            default: begin
                area_x0 = $urandom_range(0, w - area_w);
                area_y0 = $urandom_range(0, h - area_h);
            end
        endcase
    endfunction

    // Offer one transaction, with an optional idle burst ahead of it
    task automatic send_grid_item(input t_in_item item);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_grid_access(item);
    endtask

    // Drop valid, wait for every result, then let a pending write finish
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (awaited_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [3:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        case (addr)
            ADDR_MAP_WIDTH:      map_width_reg  = value[8:0];
            ADDR_MAP_HEIGHT:     map_height_reg = value[8:0];
            ADDR_INFLATE_RADIUS: radius_reg     = value[3:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_map_config(input logic [31:0] w, input logic [31:0] h,
                                    input logic [31:0] r);
        write_register(ADDR_MAP_WIDTH, w);
        write_register(ADDR_MAP_HEIGHT, h);
        write_register(ADDR_INFLATE_RADIUS, r);
    endtask

    // Load a work area, then mix reads, rewrites and out-of-range items
    task automatic run_map_phase(input logic [31:0] width_val, input logic [31:0] height_val,
                                 input logic [31:0] radius_val, input t_area_place place,
                                 input int budget, input bit idle_on, input bit squeeze);
        int sent;
        int x;
        int y;
        int roll;
        int w;
        int h;
        bit found;
        settle_block();
        tx_idle_en = idle_on;
        rx_idle_en = idle_on;
        apply_map_config(width_val, height_val, radius_val);
        place_work_area(place);
        w = clamp_dim(map_width_reg, GRID_W);
        h = clamp_dim(map_height_reg, GRID_H);
        sent = 0;
        for (y = area_y0; y < area_y0 + area_h; y++) begin
            for (x = area_x0; x < area_x0 + area_w; x++) begin
                send_grid_item(grid_item(OP_WRITE, x, y, random_pixel()));
                sent++;
            end
        end
        // Stall the output side for a long stretch while items keep coming
        if (squeeze) hold_requests++;
        while (sent < budget) begin
            roll = $urandom_range(0, 99);
            found = 1'b0;
            if (roll < 60) found = pick_readable(x, y);
            if (found) begin
                send_grid_item(grid_item(OP_READ, x, y, 8'($urandom_range(0, 255))));
            end else if (roll >= 85 && (w < GRID_W || h < GRID_H)) begin
                if (w < GRID_W && (h == GRID_H || $urandom_range(0, 1) == 1)) begin
                    x = $urandom_range(w, 255);
                    y = $urandom_range(0, 255);
                end else begin
                    x = $urandom_range(0, 255);
                    y = $urandom_range(h, 255);
                end
                send_grid_item(grid_item(logic'($urandom_range(0, 1)), x, y,
                                         8'($urandom_range(0, 255))));
            end else begin
                x = area_x0 + $urandom_range(0, area_w - 1);
                y = area_y0 + $urandom_range(0, area_h - 1);
                send_grid_item(grid_item(OP_WRITE, x, y,
                    ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : random_pixel()));
            end
            sent++;
        end
    endtask

    task automatic test_directed_cases();
        settle_block();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        apply_map_config(2, 2, 1);
        // 2x2 map with one obstacle in the far corner
        send_grid_item(grid_item(OP_WRITE, 0, 0, FREE_CELL));
        send_grid_item(grid_item(OP_WRITE, 1, 0, FREE_CELL));
        send_grid_item(grid_item(OP_WRITE, 0, 1, FREE_CELL));
        send_grid_item(grid_item(OP_WRITE, 1, 1, OBSTACLE_CELL));
        // diagonal lies outside radius one, the side neighbor inside
        send_grid_item(grid_item(OP_READ, 0, 0, 8'h00));
        send_grid_item(grid_item(OP_READ, 1, 0, 8'hFF));
        send_grid_item(grid_item(OP_READ, 1, 1, 8'h00));
        // out of range on either axis, for reads and writes
        send_grid_item(grid_item(OP_WRITE, 2, 0, 8'hAA));
        send_grid_item(grid_item(OP_READ, 0, 2, 8'h55));
        send_grid_item(grid_item(OP_READ, 255, 255, 8'hFF));
        send_grid_item(grid_item(OP_WRITE, 255, 255, 8'h00));
        // a gray value reads back as stored
        send_grid_item(grid_item(OP_WRITE, 0, 0, 8'h80));
        send_grid_item(grid_item(OP_READ, 0, 0, 8'h7F));
        send_grid_item(grid_item(OP_WRITE, 0, 0, FREE_CELL));
        // zero radius inflates nothing
        settle_block();
        apply_map_config(2, 2, 0);
        send_grid_item(grid_item(OP_READ, 1, 0, 8'h00));
        // largest radius reaches the diagonal
        settle_block();
        apply_map_config(2, 2, 15);
        send_grid_item(grid_item(OP_READ, 0, 0, 8'h00));
        // zero width clamps to one column, oversized height to the full grid
        settle_block();
        apply_map_config(0, 300, 1);
        send_grid_item(grid_item(OP_READ, 0, 0, 8'h00));
        send_grid_item(grid_item(OP_READ, 1, 0, 8'h00));
        // oversized width clamps to the full grid, one row in use
        settle_block();
        apply_map_config(511, 1, 1);
        send_grid_item(grid_item(OP_WRITE, 2, 0, OBSTACLE_CELL));
        send_grid_item(grid_item(OP_READ, 1, 0, 8'h00));
        send_grid_item(grid_item(OP_READ, 0, 1, 8'h00));
    endtask

    task automatic test_default_radius_corner();
        run_map_phase(256, 256, 4, AREA_HIGH_CORNER, 250, 1'b1, 1'b0);
    endtask

    task automatic test_output_backpressure();
        run_map_phase(256, 256, 2, AREA_ANYWHERE, 230, 1'b1, 1'b1);
    endtask

    task automatic test_max_radius_small_map();
        run_map_phase(12, 10, 15, AREA_LOW_CORNER, 220, 1'b1, 1'b0);
    endtask

    task automatic test_clamped_sizes();
        run_map_phase(0, 5, 2, AREA_LOW_CORNER, 60, 1'b1, 1'b0);
        run_map_phase(300, 3, 3, AREA_HIGH_CORNER, 150, 1'b1, 1'b0);
    endtask

    task automatic test_random_maps();
        repeat (3) begin
            run_map_phase($urandom_range(2, 20), $urandom_range(2, 20), $urandom_range(0, 6),
                          t_area_place'($urandom_range(0, 2)), 200, 1'b1, 1'b0);
        end
    endtask

    task automatic test_steady_stream();
        run_map_phase(20, 16, 5, AREA_ANYWHERE, 230, 1'b0, 1'b0);
    endtask

    // Output side: random stall bursts and the requested long hold
    initial begin : output_side
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served < hold_requests) begin
                hold_served++;
                stall_left = LONG_HOLD_CYCLES;
            end else if (stall_left == 0 && rx_idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 10);
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Match each accepted result against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected result value=%0d err=%0b",
                                          o_out_data.cell_value, o_out_data.coord_error));
            end else begin
                want = awaited_outputs.pop_front();
                if (o_out_data.cell_value !== want.cell_value) begin
                    report_mismatch($sformatf("result %0d cell_value got %0d want %0d",
                        result_index, o_out_data.cell_value, want.cell_value));
                end
                if (o_out_data.coord_error !== want.coord_error) begin
                    report_mismatch($sformatf("result %0d coord_error got %0b want %0b",
                        result_index, o_out_data.coord_error, want.coord_error));
                end
            end
            result_index++;
        end
    end

    initial begin : run_tests
        int waited;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_default_radius_corner();
        test_output_backpressure();
        test_max_radius_small_map();
        test_clamped_sizes();
        test_random_maps();
        test_steady_stream();

        // Drain outstanding results, bounded
        i_in_valid <= 1'b0;
        waited = 0;
        while (awaited_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (awaited_outputs.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", awaited_outputs.size()));
        end
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
